FILE: rtl/itda_pkg.sv
`default_nettype none
package itda_pkg;

	localparam int VALUE_BITS = 32;
	localparam int MAX_CHARS  = 20;

	// decimal digits that hold any magnitude up to 2^(VALUE_BITS-1)
	localparam int BCD_DIGITS = (VALUE_BITS * 1233) / 4096 + 1;
	localparam int TXT_MAX    = (MAX_CHARS > BCD_DIGITS + 1) ? MAX_CHARS : BCD_DIGITS + 1;
	localparam int CW         = $clog2(TXT_MAX + 1);
	localparam int DW         = $clog2(BCD_DIGITS + 1);
	localparam int DIW        = $clog2(BCD_DIGITS);
	localparam int BW         = $clog2(VALUE_BITS);
	localparam int MW_BITS    = 5;

	localparam int QDEPTH = 2;
	localparam int QPW    = $clog2(QDEPTH);
	localparam int QCW    = $clog2(QDEPTH + 1);

	localparam logic [6:0] CH_ZERO  = 7'd48;
	localparam logic [6:0] CH_MINUS = 7'd45;
	localparam logic [6:0] CH_SPACE = 7'd32;

	typedef struct packed {
		logic                  neg;
		logic [VALUE_BITS-1:0] mag;
	} item_t;

endpackage
`default_nettype wire

FILE: rtl/itda_front.sv
`default_nettype none
module itda_front
	import itda_pkg::*;
(
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         in_valid,
	output logic                              in_ready,
	input  wire logic signed [VALUE_BITS-1:0] value,
	output logic                              push_valid,
	input  wire logic                         push_ready,
	output item_t                             push_item
);

	logic  valid_s1;
	item_t item_s1;
	logic  neg;

	assign neg        = value[VALUE_BITS-1];
	assign in_ready   = !valid_s1 || push_ready;
	assign push_valid = valid_s1;
	assign push_item  = item_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1.neg <= neg;
			item_s1.mag <= neg ? (~value + 1'b1) : value;
		end
	end

endmodule
`default_nettype wire

FILE: rtl/itda_queue.sv
`default_nettype none
module itda_queue
	import itda_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  wr_valid,
	output logic       wr_ready,
	input  wire item_t wr_item,
	output logic       rd_valid,
	input  wire logic  rd_ready,
	output item_t      rd_item
);

	item_t          mem_q [QDEPTH];
	logic [QPW-1:0] wr_ptr_q;
	logic [QPW-1:0] rd_ptr_q;
	logic [QCW-1:0] count_q;
	logic           do_wr;
	logic           do_rd;

	assign wr_ready = (count_q != QCW'(QDEPTH));
	assign rd_valid = (count_q != '0);
	assign rd_item  = mem_q[rd_ptr_q];
	assign do_wr    = wr_valid && wr_ready;
	assign do_rd    = rd_valid && rd_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == QPW'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == QPW'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (!do_wr && do_rd) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_item;
		end
	end

`ifndef SYNTHESIS
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= QCW'(QDEPTH)) else $error("queue count out of range");
	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		(do_wr && !do_rd) |=> count_q == $past(count_q) + 1'b1)
		else $error("queue count did not advance on write");
	a_empty_ptrs: assert property (@(posedge clk) disable iff (!arst_n)
		count_q == '0 |-> wr_ptr_q == rd_ptr_q) else $error("empty queue with pointer skew");
`endif

endmodule
`default_nettype wire

FILE: rtl/itda_back.sv
`default_nettype none
module itda_back
	import itda_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic [MW_BITS-1:0] min_width,
	input  wire logic               req_valid,
	output logic                    req_ready,
	input  wire item_t              req_item,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic [6:0]              char_code,
	output logic                    last_char
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_CONV = 2'd1;
	localparam logic [1:0] ST_SIZE = 2'd2;
	localparam logic [1:0] ST_EMIT = 2'd3;

	logic [1:0]            state_q;
	logic [BW-1:0]         bit_cnt_q;
	logic [VALUE_BITS-1:0] mag_q;
	logic                  neg_q;
	logic [3:0]            bcd_q [BCD_DIGITS];
	logic [3:0]            bcd_n [BCD_DIGITS];
	logic [3:0]            adj   [BCD_DIGITS];
	logic [CW-1:0]         pad_q;
	logic                  sign_q;
	logic [DW-1:0]         dig_left_q;

	logic [DW-1:0]  ndig;
	logic [CW-1:0]  textlen;
	logic [CW-1:0]  width;
	logic [DIW-1:0] dig_idx;
	logic [3:0]     cur_digit;
	logic           load;
	logic [6:0]     nxt_char;
	logic           nxt_last;

	logic           out_valid_q;
	logic [6:0]     char_q;
	logic           last_q;

	always_comb begin
		for (int i = 0; i < BCD_DIGITS; i++) begin
			adj[i] = (bcd_q[i] >= 4'd5) ? bcd_q[i] + 4'd3 : bcd_q[i];
		end
		bcd_n[0] = {adj[0][2:0], mag_q[VALUE_BITS-1]};
		for (int i = 1; i < BCD_DIGITS; i++) begin
			bcd_n[i] = {adj[i][2:0], adj[i-1][3]};
		end
	end

	always_comb begin
		ndig = DW'(1);
		for (int i = 1; i < BCD_DIGITS; i++) begin
			if (bcd_q[i] != 4'd0) begin
				ndig = DW'(i + 1);
			end
		end
		textlen = CW'(ndig) + CW'(neg_q);
		if (32'(min_width) > 32'(MAX_CHARS)) begin
			width = CW'(MAX_CHARS);
		end else begin
			width = CW'(min_width);
		end
	end

	assign dig_idx   = DIW'(dig_left_q - 1'b1);
	assign cur_digit = bcd_q[dig_idx];
	assign load      = (state_q == ST_EMIT) && (!out_valid_q || out_ready);
	assign req_ready = (state_q == ST_IDLE);

	always_comb begin
		nxt_last = 1'b0;
		if (pad_q != '0) begin
			nxt_char = CH_SPACE;
		end else if (sign_q) begin
			nxt_char = CH_MINUS;
		end else begin
			nxt_char = CH_ZERO + 7'(cur_digit);
			nxt_last = (dig_left_q == DW'(1));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (req_valid) begin
						state_q <= ST_CONV;
					end
				end
				ST_CONV: begin
					if (bit_cnt_q == '0) begin
						state_q <= ST_SIZE;
					end
				end
				ST_SIZE: begin
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (load && nxt_last) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (req_valid) begin
					mag_q     <= req_item.mag;
					neg_q     <= req_item.neg;
					bit_cnt_q <= BW'(VALUE_BITS - 1);
					for (int i = 0; i < BCD_DIGITS; i++) begin
						bcd_q[i] <= 4'd0;
					end
				end
			end
			ST_CONV: begin
				bcd_q     <= bcd_n;
				mag_q     <= {mag_q[VALUE_BITS-2:0], 1'b0};
				bit_cnt_q <= bit_cnt_q - 1'b1;
			end
			ST_SIZE: begin
				pad_q      <= (width > textlen) ? width - textlen : '0;
				sign_q     <= neg_q;
				dig_left_q <= ndig;
			end
			ST_EMIT: begin
				if (load) begin
					if (pad_q != '0) begin
						pad_q <= pad_q - 1'b1;
					end else if (sign_q) begin
						sign_q <= 1'b0;
					end else begin
						dig_left_q <= dig_left_q - 1'b1;
					end
				end
			end
			default: begin
			end
		endcase
		if (load) begin
			char_q <= nxt_char;
			last_q <= nxt_last;
		end
	end

	assign out_valid = out_valid_q;
	assign char_code = char_q;
	assign last_char = last_q;

`ifndef SYNTHESIS
	a_digits_left: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_EMIT |-> dig_left_q != '0) else $error("emitting with no digits left");
	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(load && nxt_last) |=> state_q == ST_IDLE && out_valid_q && last_q)
		else $error("final character did not end the run");
	a_pop_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && req_ready) |=> state_q == ST_CONV)
		else $error("request taken without conversion");
`endif

endmodule
`default_nettype wire

FILE: rtl/int_to_decimal_ascii_padded.sv
// Signed integer to padded decimal ASCII text.
// Input channel in_valid/in_ready carries one two's complement value per
// request. Output channel out_valid/out_ready returns its text one character
// per transfer, most significant first: spaces up to min_width (capped at
// MAX_CHARS), a minus sign for negative values, then the digits. last_char
// marks the final character of each value.
// Config channel cfg_valid/cfg_ready writes min_width; cfg_ready is always
// high. Write it only while no conversion is in flight.
// A front stage registers the sign and magnitude, a two-entry queue
// decouples it from the converter. The converter runs a shift-add-3 BCD
// loop, one input bit per cycle, then a sizing step, then emits one character
// per cycle from a registered output while the receiver is ready. Each value
// yields 1 to 20 characters.
// A stalled receiver holds the output register and the converter; the queue
// keeps accepting until it and the front stage are full.
// Reset clears all handshake state and sets min_width to 0.
`default_nettype none
module int_to_decimal_ascii_padded
	import itda_pkg::*;
(
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         in_valid,
	output logic                              in_ready,
	input  wire logic signed [VALUE_BITS-1:0] value,
	output logic                              out_valid,
	input  wire logic                         out_ready,
	output logic [6:0]                        char_code,
	output logic                              last_char,
	input  wire logic                         cfg_valid,
	output logic                              cfg_ready,
	input  wire logic [MW_BITS-1:0]           cfg_data
);

	logic [MW_BITS-1:0] min_width_q;
	logic               f_valid;
	logic               f_ready;
	item_t              f_item;
	logic               b_valid;
	logic               b_ready;
	item_t              b_item;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_width_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			min_width_q <= cfg_data;
		end
	end

	itda_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.value      (value),
		.push_valid (f_valid),
		.push_ready (f_ready),
		.push_item  (f_item)
	);

	itda_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_valid (f_valid),
		.wr_ready (f_ready),
		.wr_item  (f_item),
		.rd_valid (b_valid),
		.rd_ready (b_ready),
		.rd_item  (b_item)
	);

	itda_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.min_width (min_width_q),
		.req_valid (b_valid),
		.req_ready (b_ready),
		.req_item  (b_item),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.char_code (char_code),
		.last_char (last_char)
	);

endmodule
`default_nettype wire
